// File: hw/rtl/gwmr_pkg.sv
// ----------------------------------------------------------------------------
// gwmr_pkg
// Shared types and constants for the grid wall merge and relabel block.
// ----------------------------------------------------------------------------
package gwmr_pkg;

	// default geometry of the label store
	localparam int GRID_COLS_DEF  = 64;
	localparam int GRID_ROWS_DEF  = 64;
	localparam int LABEL_BITS_DEF = 16;

	// item operation codes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_MERGE = 2'd2;

	// neighbour direction codes
	localparam logic [1:0] DIR_RIGHT = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	// configuration register indexes and reset values
	localparam logic REG_LAST_COL = 1'b0;
	localparam logic REG_LAST_ROW = 1'b1;
	localparam logic [5:0] LAST_COL_RST = 6'd63;
	localparam logic [5:0] LAST_ROW_RST = 6'd63;

	// read of a cell outside the store answers as border
	localparam logic [15:0] READ_BORDER = 16'hFFFF;

	// scan limits handed from the register file to the sequencer
	typedef struct packed {
		logic [5:0] last_col;
		logic [5:0] last_row;
	} cfg_t;

endpackage

// File: hw/rtl/gwmr_in_if.sv
// ----------------------------------------------------------------------------
// gwmr_in_if
// Input item channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface gwmr_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [5:0]         col;
	logic [5:0]         row;
	logic signed [15:0] cell_value;
	logic [1:0]         dir_a;
	logic [1:0]         dir_b;

	modport source (output valid, mode, col, row, cell_value, dir_a, dir_b, input ready);
	modport sink (input valid, mode, col, row, cell_value, dir_a, dir_b, output ready);
endinterface

// File: hw/rtl/gwmr_out_if.sv
// ----------------------------------------------------------------------------
// gwmr_out_if
// Result item channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface gwmr_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] read_value;
	logic               merged;

	modport source (output valid, read_value, merged, input ready);
	modport sink (input valid, read_value, merged, output ready);
endinterface

// File: hw/rtl/gwmr_ram.sv
// ----------------------------------------------------------------------------
// gwmr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gwmr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/gwmr_cfg.sv
// ----------------------------------------------------------------------------
// gwmr_cfg
// APB register file holding the relabel scan limits.
// ----------------------------------------------------------------------------
module gwmr_cfg import gwmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [5:0] last_col_q;
	logic [5:0] last_row_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= LAST_COL_RST;
			last_row_q <= LAST_ROW_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_LAST_COL: last_col_q <= pwdata[5:0];
				REG_LAST_ROW: last_row_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		case (paddr[2])
			REG_LAST_COL: prdata = {26'd0, last_col_q};
			REG_LAST_ROW: prdata = {26'd0, last_row_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.last_col = last_col_q;
	assign cfg.last_row = last_row_q;

endmodule

// File: hw/rtl/gwmr_ctrl.sv
// ----------------------------------------------------------------------------
// gwmr_ctrl
// Item sequencer: cell write/read, neighbour fetch and the relabel sweep,
// one label RAM read and at most one write per cycle.
// ----------------------------------------------------------------------------
module gwmr_ctrl import gwmr_pkg::*; #(
	parameter int GRID_COLS  = GRID_COLS_DEF,
	parameter int GRID_ROWS  = GRID_ROWS_DEF,
	parameter int LABEL_BITS = LABEL_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	gwmr_in_if.sink                               req,
	gwmr_out_if.source                            rsp,
	input  cfg_t                                  cfg,
	output logic                                  mem_we,
	output logic [$clog2(GRID_ROWS*GRID_COLS)-1:0] mem_waddr,
	output logic [LABEL_BITS-1:0]                 mem_wdata,
	output logic [$clog2(GRID_ROWS*GRID_COLS)-1:0] mem_raddr,
	input  logic [LABEL_BITS-1:0]                 mem_rdata
);

	localparam int ADDR_W = $clog2(GRID_ROWS * GRID_COLS);
	localparam int CW     = $clog2(GRID_COLS);
	localparam int RW     = $clog2(GRID_ROWS);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_ISSUE = 9'b000000010,
		S_RDCAP = 9'b000000100,
		S_NB_B  = 9'b000001000,
		S_NB_C  = 9'b000010000,
		S_CMP   = 9'b000100000,
		S_SCAN  = 9'b001000000,
		S_DRAIN = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t                   state_q;
	logic [1:0]               mode_q;
	logic [5:0]               row_q;
	logic [5:0]               col_q;
	logic [LABEL_BITS-1:0]    wval_q;
	logic [1:0]               dir_a_q;
	logic [1:0]               dir_b_q;
	logic signed [LABEL_BITS-1:0] a_q;
	logic signed [LABEL_BITS-1:0] b_q;
	logic signed [LABEL_BITS-1:0] lo_q;
	logic signed [LABEL_BITS-1:0] hi_q;
	logic [CW-1:0]            x_q;
	logic [RW-1:0]            y_q;
	logic                     scan_vld_s1;
	logic [ADDR_W-1:0]        scan_addr_s1;
	logic [15:0]              read_value_q;
	logic                     merged_q;

	logic                     in_store;
	logic [ADDR_W-1:0]        item_addr;
	logic [CW-1:0]            cmax;
	logic [RW-1:0]            rmax;
	logic [31:0]              cmax_full;
	logic [31:0]              rmax_full;
	logic                     last_x;
	logic                     last_y;
	logic                     a_lt_b;
	logic                     do_join;
	logic signed [LABEL_BITS-1:0] rd_label;
	logic [31:0]              rd_ext;
	logic [31:0]              wv_ext;

	// linear address of a cell
	function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned r, input int unsigned c);
		int unsigned t;
		t = r * GRID_COLS + c;
		return t[ADDR_W-1:0];
	endfunction

	// whether the neighbour in a direction lies inside the store
	function automatic logic nb_ok(input logic [1:0] dir, input logic [5:0] r,
			input logic [5:0] c);
		logic ok;
		case (dir)
			DIR_RIGHT: ok = (int'(c) + 1) < GRID_COLS;
			DIR_LEFT:  ok = c != 6'd0;
			DIR_UP:    ok = r != 6'd0;
			DIR_DOWN:  ok = (int'(r) + 1) < GRID_ROWS;
			default:   ok = 1'b0;
		endcase
		return ok;
	endfunction

	// address of the neighbour in a direction
	function automatic logic [ADDR_W-1:0] nb_addr(input logic [1:0] dir, input logic [5:0] r,
			input logic [5:0] c);
		logic [ADDR_W-1:0] a;
		case (dir)
			DIR_RIGHT: a = cell_addr(int'(r), int'(c) + 1);
			DIR_LEFT:  a = cell_addr(int'(r), int'(c) - 1);
			DIR_UP:    a = cell_addr(int'(r) - 1, int'(c));
			DIR_DOWN:  a = cell_addr(int'(r) + 1, int'(c));
			default:   a = '0;
		endcase
		return a;
	endfunction

	assign in_store  = (int'(row_q) < GRID_ROWS) && (int'(col_q) < GRID_COLS);
	assign item_addr = cell_addr(int'(row_q), int'(col_q));

	// scan limits clamped to the store
	assign cmax_full = (int'(cfg.last_col) > GRID_COLS - 1) ? 32'(GRID_COLS - 1)
		: 32'(cfg.last_col);
	assign rmax_full = (int'(cfg.last_row) > GRID_ROWS - 1) ? 32'(GRID_ROWS - 1)
		: 32'(cfg.last_row);
	assign cmax   = cmax_full[CW-1:0];
	assign rmax   = rmax_full[RW-1:0];
	assign last_x = x_q == cmax;
	assign last_y = y_q == rmax;

	// join test on the two neighbour labels
	assign a_lt_b  = a_q < b_q;
	assign do_join = (a_q != b_q) && (a_q != '1) && (b_q != '1)
		&& (a_q != '0) && (b_q != '0);

	assign rd_label = mem_rdata;
	assign rd_ext   = 32'(rd_label);
	assign wv_ext   = 32'(req.cell_value);

	// label RAM port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		case (state_q)
			S_ISSUE: begin
				case (mode_q)
					MODE_WRITE: begin
						mem_we    = in_store;
						mem_waddr = item_addr;
						mem_wdata = wval_q;
					end
					MODE_READ:  mem_raddr = item_addr;
					MODE_MERGE: mem_raddr = nb_addr(dir_a_q, row_q, col_q);
					default: ;
				endcase
			end
			S_NB_B: mem_raddr = nb_addr(dir_b_q, row_q, col_q);
			S_CMP: begin
				mem_we    = do_join;
				mem_waddr = item_addr;
				mem_wdata = a_lt_b ? a_q : b_q;
			end
			S_SCAN: mem_raddr = cell_addr(int'(y_q), int'(x_q));
			default: ;
		endcase
		// sweep write-back of cells holding the larger label
		if (scan_vld_s1 && (rd_label == hi_q)) begin
			mem_we    = 1'b1;
			mem_waddr = scan_addr_s1;
			mem_wdata = lo_q;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= state_q == S_SCAN;
			case (state_q)
				S_IDLE: if (req.valid) state_q <= S_ISSUE;
				S_ISSUE: begin
					if (mode_q == MODE_READ && in_store) begin
						state_q <= S_RDCAP;
					end else if (mode_q == MODE_MERGE && in_store) begin
						state_q <= S_NB_B;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_RDCAP: state_q <= S_OUT;
				S_NB_B:  state_q <= S_NB_C;
				S_NB_C:  state_q <= S_CMP;
				S_CMP:   state_q <= do_join ? S_SCAN : S_OUT;
				S_SCAN:  if (last_x && last_y) state_q <= S_DRAIN;
				S_DRAIN: state_q <= S_OUT;
				S_OUT:   if (rsp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item, label and result registers
	always_ff @(posedge clk) begin
		scan_addr_s1 <= cell_addr(int'(y_q), int'(x_q));
		case (state_q)
			S_IDLE: begin
				mode_q  <= req.mode;
				row_q   <= req.row;
				col_q   <= req.col;
				wval_q  <= wv_ext[LABEL_BITS-1:0];
				dir_a_q <= req.dir_a;
				dir_b_q <= req.dir_b;
			end
			S_ISSUE: begin
				merged_q     <= 1'b0;
				read_value_q <= (mode_q == MODE_READ && !in_store) ? READ_BORDER : 16'd0;
			end
			S_RDCAP: read_value_q <= rd_ext[15:0];
			S_NB_B:  a_q <= nb_ok(dir_a_q, row_q, col_q) ? rd_label : '1;
			S_NB_C:  b_q <= nb_ok(dir_b_q, row_q, col_q) ? rd_label : '1;
			S_CMP: begin
				lo_q <= a_lt_b ? a_q : b_q;
				hi_q <= a_lt_b ? b_q : a_q;
				x_q  <= '0;
				y_q  <= '0;
			end
			S_SCAN: begin
				if (last_x) begin
					x_q <= '0;
					y_q <= y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			S_DRAIN: merged_q <= 1'b1;
			default: ;
		endcase
	end

	assign req.ready      = state_q == S_IDLE;
	assign rsp.valid      = state_q == S_OUT;
	assign rsp.read_value = read_value_q;
	assign rsp.merged     = merged_q;

endmodule

// File: hw/rtl/grid_wall_merge_relabel_core.sv
// ----------------------------------------------------------------------------
// grid_wall_merge_relabel_core
// Grid of signed set labels with cell write, cell read and wall merge.
// ----------------------------------------------------------------------------
// Items are handled one at a time; req.ready is low from acceptance until
// the result item has been taken. A merge that joins two sets runs a
// relabel sweep over rows 0 to last_row and columns 0 to last_col:
// the sweep reads one cell per cycle from the label RAM and writes
// back cells that hold the larger label through its second port, so the
// single RAM read port sets the sweep length. The label store has no reset;
// a cell must be written before it is read or used as a merge neighbour.
// ----------------------------------------------------------------------------
module grid_wall_merge_relabel_core import gwmr_pkg::*; #(
	parameter int GRID_COLS  = GRID_COLS_DEF,
	parameter int GRID_ROWS  = GRID_ROWS_DEF,
	parameter int LABEL_BITS = LABEL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	gwmr_in_if.sink     req,
	gwmr_out_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DEPTH  = GRID_ROWS * GRID_COLS;
	localparam int ADDR_W = $clog2(DEPTH);

	cfg_t                  cfg;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [LABEL_BITS-1:0] mem_wdata;
	logic [ADDR_W-1:0]     mem_raddr;
	logic [LABEL_BITS-1:0] mem_rdata;

	// scan limit registers
	gwmr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// item sequencer
	gwmr_ctrl #(
		.GRID_COLS  (GRID_COLS),
		.GRID_ROWS  (GRID_ROWS),
		.LABEL_BITS (LABEL_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg       (cfg),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// label store
	gwmr_ram #(
		.WIDTH (LABEL_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid wall merge and relabel core: it keeps its
// own copy of the label grid and scan limits, predicts the answer to every
// accepted item, and compares each result item with the oldest prediction.
// Written cells are tracked as items are sent, so no read item or merge
// neighbour ever names an unwritten cell.
// ----------------------------------------------------------------------------
module tb_top;
	import gwmr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// mode code the block leaves unused
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// special labels
	localparam logic signed [15:0] BORDER_LBL = -16'sd1;
	localparam logic signed [15:0] WALL_LBL   = 16'sd0;

	// worst case: every merge item sweeps the full grid behind full idling,
	// plus the long hold-off, taken several times over
	localparam int unsigned LIMIT_CYCLES = 3_000_000;
	localparam int          HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic [1:0]         mode;
		logic [5:0]         col;
		logic [5:0]         row;
		logic signed [15:0] cell_value;
		logic [1:0]         dir_a;
		logic [1:0]         dir_b;
	} grid_cmd_t;

	typedef struct packed {
		logic signed [15:0] read_value;
		logic               merged;
	} grid_ans_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	gwmr_in_if  req_ch ();
	gwmr_out_if rsp_ch ();

	grid_wall_merge_relabel_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the label store and scan limits
	logic signed [15:0] grid_lbl [GRID_ROWS_DEF][GRID_COLS_DEF];
	logic [5:0]         scan_last_col = LAST_COL_RST;
	logic [5:0]         scan_last_row = LAST_ROW_RST;

	// cells that a write item has been sent to
	bit        cell_set [GRID_ROWS_DEF][GRID_COLS_DEF];

	grid_ans_t answer_q [$];
	int        fail_cnt = 0;
	bit        src_idle = 1'b0;
	bit        sink_idle = 1'b0;
	int        hold_cycles = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	function automatic bit in_store(input int r, input int c);
		return r >= 0 && c >= 0 && r < GRID_ROWS_DEF && c < GRID_COLS_DEF;
	endfunction

	// coordinates of the neighbour in direction d
	function automatic void step_coord(input int r, input int c, input logic [1:0] d,
			output int nr, output int nc);
		nr = r;
		nc = c;
		case (d)
			DIR_RIGHT: nc = c + 1;
			DIR_LEFT:  nc = c - 1;
			DIR_UP:    nr = r - 1;
			DIR_DOWN:  nr = r + 1;
			default: ;
		endcase
	endfunction

	function automatic logic signed [15:0] nb_label(input int r, input int c,
			input logic [1:0] d);
		int nr, nc;
		step_coord(r, c, d, nr, nc);
		if (!in_store(nr, nc))
			return BORDER_LBL;
		return grid_lbl[nr][nc];
	endfunction

	// expected answer of one item, updating the shadow grid
	function automatic grid_ans_t apply_grid_op(input grid_cmd_t cmd);
		grid_ans_t          ans;
		logic signed [15:0] la, lb, lo, hi;
		int                 y, x;
		ans = '0;
		case (cmd.mode)
			MODE_WRITE: grid_lbl[cmd.row][cmd.col] = cmd.cell_value;
			MODE_READ:  ans.read_value = grid_lbl[cmd.row][cmd.col];
			MODE_MERGE: begin
				la = nb_label(cmd.row, cmd.col, cmd.dir_a);
				lb = nb_label(cmd.row, cmd.col, cmd.dir_b);
				lo = (la < lb) ? la : lb;
				hi = (la < lb) ? lb : la;
				if (lo != hi && lo != BORDER_LBL && hi != BORDER_LBL &&
						lo != WALL_LBL && hi != WALL_LBL) begin
					// wall joins the smaller set, then the active area is relabelled
					grid_lbl[cmd.row][cmd.col] = lo;
					for (y = 0; y <= int'(scan_last_row); y++)
						for (x = 0; x <= int'(scan_last_col); x++)
							if (grid_lbl[y][x] == hi)
								grid_lbl[y][x] = lo;
					ans.merged = 1'b1;
				end
			end
			default: ;
		endcase
		return ans;
	endfunction

	// prediction at every accepted item
	always @(posedge clk) begin : accept_track
		grid_cmd_t cmd;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			cmd.mode       = req_ch.mode;
			cmd.col        = req_ch.col;
			cmd.row        = req_ch.row;
			cmd.cell_value = req_ch.cell_value;
			cmd.dir_a      = req_ch.dir_a;
			cmd.dir_b      = req_ch.dir_b;
			answer_q.push_back(apply_grid_op(cmd));
		end
	end

	// compare every result item with the oldest prediction
	always @(posedge clk) begin : result_check
		grid_ans_t exp_ans;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (answer_q.size() == 0) begin
				$display("%0t: unexpected result item, read_value %0d merged %0b",
					$time, rsp_ch.read_value, rsp_ch.merged);
				fail_cnt++;
			end else begin
				exp_ans = answer_q.pop_front();
				if (rsp_ch.read_value !== exp_ans.read_value) begin
					$display("%0t: read_value expected %0d actual %0d",
						$time, exp_ans.read_value, rsp_ch.read_value);
					fail_cnt++;
				end
				if (rsp_ch.merged !== exp_ans.merged) begin
					$display("%0t: merged expected %0b actual %0b",
						$time, exp_ans.merged, rsp_ch.merged);
					fail_cnt++;
				end
			end
		end
	end

	// result side: random stalls and a long hold-off on request
	initial begin : result_sink
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = sink_idle ? $urandom_range(17, 0) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk);
			while (!(rsp_ch.valid && rsp_ch.ready) && hold_cycles == 0);
		end
	end

	// offer one item and wait until it is taken
	task automatic send_op(input logic [1:0] mode, input int row, input int col,
			input int val, input logic [1:0] da, input logic [1:0] db);
		int gap;
		gap = src_idle ? $urandom_range(17, 0) : 0;
		if (mode == MODE_WRITE)
			cell_set[row][col] = 1'b1;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= mode;
		req_ch.row        <= 6'(row);
		req_ch.col        <= 6'(col);
		req_ch.cell_value <= 16'(val);
		req_ch.dir_a      <= da;
		req_ch.dir_b      <= db;
		do @(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
	endtask

	// stop offering and wait until every predicted result has come
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk);
		while (answer_q.size() != 0);
	endtask

	task automatic apb_write(input logic idx, input logic [5:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_LAST_COL: scan_last_col = val;
			REG_LAST_ROW: scan_last_row = val;
			default: ;
		endcase
	endtask

	task automatic set_scan(input int lc, input int lr);
		apb_write(REG_LAST_COL, 6'(lc));
		apb_write(REG_LAST_ROW, 6'(lr));
	endtask

	// mostly small set labels, sometimes wall, border or a large label
	function automatic int rand_label();
		case ($urandom_range(9, 0))
			0:       return 0;
			1:       return -1;
			2:       return 32767;
			3:       return $urandom_range(32767, 1);
			default: return $urandom_range(12, 1);
		endcase
	endfunction

	// coordinate biased towards the active area
	function automatic int pick_coord(input int last);
		if ($urandom_range(9, 0) < 7)
			return $urandom_range(last, 0);
		return $urandom_range(63, 0);
	endfunction

	function automatic logic [1:0] rand_dir();
		return 2'($urandom_range(3, 0));
	endfunction

	// give a cell inside the store a label before it is read
	task automatic ensure_set(input int r, input int c);
		if (in_store(r, c) && !cell_set[r][c])
			send_op(MODE_WRITE, r, c, $urandom_range(12, 1), rand_dir(), rand_dir());
	endtask

	// one item of random kind and content
	task automatic send_random_op(input int lc, input int lr);
		int         sel, r, c, nr, nc;
		logic [1:0] da, db;
		sel = $urandom_range(19, 0);
		if (sel < 6) begin
			send_op(MODE_WRITE, pick_coord(lr), pick_coord(lc), rand_label(),
				rand_dir(), rand_dir());
		end else if (sel < 11) begin
			r = pick_coord(lr);
			c = pick_coord(lc);
			ensure_set(r, c);
			send_op(MODE_READ, r, c, rand_label(), rand_dir(), rand_dir());
		end else if (sel < 19) begin
			r  = pick_coord(lr);
			c  = pick_coord(lc);
			da = rand_dir();
			db = rand_dir();
			step_coord(r, c, da, nr, nc);
			ensure_set(nr, nc);
			step_coord(r, c, db, nr, nc);
			ensure_set(nr, nc);
			send_op(MODE_MERGE, r, c, rand_label(), da, db);
		end else begin
			send_op(MODE_UNUSED, $urandom_range(63, 0), $urandom_range(63, 0),
				rand_label(), rand_dir(), rand_dir());
		end
	endtask

	// label two neighbours, usually wall the cell between them, merge, maybe read back
	task automatic send_merge_setup(input int lc, input int lr);
		int         r, c, nr, nc, val;
		logic [1:0] da, db;
		r  = pick_coord(lr);
		c  = pick_coord(lc);
		da = rand_dir();
		db = ($urandom_range(9, 0) == 0) ? da : rand_dir();
		step_coord(r, c, da, nr, nc);
		if (in_store(nr, nc)) begin
			val = ($urandom_range(5, 0) == 0) ? rand_label() : $urandom_range(12, 1);
			send_op(MODE_WRITE, nr, nc, val, rand_dir(), rand_dir());
		end
		step_coord(r, c, db, nr, nc);
		if (in_store(nr, nc)) begin
			val = ($urandom_range(5, 0) == 0) ? rand_label() : $urandom_range(12, 1);
			send_op(MODE_WRITE, nr, nc, val, rand_dir(), rand_dir());
		end
		if ($urandom_range(4, 0) != 0)
			send_op(MODE_WRITE, r, c, WALL_LBL, rand_dir(), rand_dir());
		send_op(MODE_MERGE, r, c, rand_label(), da, db);
		if ($urandom_range(1, 0) == 1 && cell_set[r][c])
			send_op(MODE_READ, r, c, rand_label(), rand_dir(), rand_dir());
	endtask

	task automatic run_random(input int n, input int lc, input int lr);
		repeat (n) begin
			if ($urandom_range(2, 0) == 0)
				send_merge_setup(lc, lr);
			else
				send_random_op(lc, lr);
		end
		wait_drained();
	endtask

	// extremes, every mode and the merge corner cases
	task automatic test_directed();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		send_op(MODE_WRITE, 0, 0, 32767, DIR_RIGHT, DIR_RIGHT);
		send_op(MODE_READ, 0, 0, 0, DIR_LEFT, DIR_UP);
		send_op(MODE_WRITE, 63, 63, -1, DIR_DOWN, DIR_DOWN);
		send_op(MODE_READ, 63, 63, -1, DIR_DOWN, DIR_UP);
		// neighbours off the store read as border
		send_op(MODE_MERGE, 0, 0, 0, DIR_LEFT, DIR_UP);
		send_op(MODE_MERGE, 63, 63, 0, DIR_RIGHT, DIR_DOWN);
		// plain left/right merge, larger label second, on the right
		send_op(MODE_WRITE, 10, 9, 3, DIR_RIGHT, DIR_LEFT);
		send_op(MODE_WRITE, 10, 11, 7, DIR_UP, DIR_DOWN);
		send_op(MODE_WRITE, 10, 10, WALL_LBL, DIR_RIGHT, DIR_RIGHT);
		send_op(MODE_MERGE, 10, 10, 0, DIR_LEFT, DIR_RIGHT);
		send_op(MODE_READ, 10, 11, 0, DIR_RIGHT, DIR_RIGHT);
		send_op(MODE_READ, 10, 10, 0, DIR_RIGHT, DIR_RIGHT);
		// equal labels and the same neighbour twice
		send_op(MODE_MERGE, 10, 10, 0, DIR_LEFT, DIR_RIGHT);
		send_op(MODE_MERGE, 10, 10, 0, DIR_RIGHT, DIR_RIGHT);
		// wall and border neighbours block the merge
		send_op(MODE_WRITE, 9, 10, WALL_LBL, DIR_RIGHT, DIR_RIGHT);
		send_op(MODE_MERGE, 10, 10, 0, DIR_UP, DIR_LEFT);
		send_op(MODE_WRITE, 11, 10, -1, DIR_RIGHT, DIR_RIGHT);
		send_op(MODE_MERGE, 10, 10, 0, DIR_DOWN, DIR_LEFT);
		// unused mode with every field bit set
		send_op(MODE_UNUSED, 63, 63, -1, DIR_DOWN, DIR_DOWN);
		// up/down merge with the smaller label second
		send_op(MODE_WRITE, 20, 20, WALL_LBL, DIR_LEFT, DIR_LEFT);
		send_op(MODE_WRITE, 19, 20, 9, DIR_LEFT, DIR_LEFT);
		send_op(MODE_WRITE, 21, 20, 4, DIR_LEFT, DIR_LEFT);
		send_op(MODE_MERGE, 20, 20, 0, DIR_UP, DIR_DOWN);
		send_op(MODE_READ, 19, 20, 0, DIR_UP, DIR_DOWN);
		send_op(MODE_READ, 21, 20, 0, DIR_UP, DIR_DOWN);
		wait_drained();
	endtask

	task automatic test_random_full_grid();
		set_scan(63, 63);
		run_random(15, 63, 63);
	endtask

	// relabel bounded by the scan limits
	task automatic test_scan_limits();
		set_scan(7, 3);
		// wall cell beyond the active area still joins the smaller set
		send_op(MODE_WRITE, 30, 29, 5, DIR_UP, DIR_UP);
		send_op(MODE_WRITE, 30, 31, 11, DIR_UP, DIR_UP);
		send_op(MODE_WRITE, 2, 2, 11, DIR_UP, DIR_UP);
		send_op(MODE_WRITE, 40, 40, 11, DIR_UP, DIR_UP);
		send_op(MODE_WRITE, 30, 30, WALL_LBL, DIR_UP, DIR_UP);
		send_op(MODE_MERGE, 30, 30, 0, DIR_RIGHT, DIR_LEFT);
		send_op(MODE_READ, 30, 30, 0, DIR_UP, DIR_UP);
		send_op(MODE_READ, 2, 2, 0, DIR_UP, DIR_UP);
		send_op(MODE_READ, 40, 40, 0, DIR_UP, DIR_UP);
		send_op(MODE_READ, 30, 31, 0, DIR_UP, DIR_UP);
		run_random(8, 7, 3);
		// a stretch with no idling on either side
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		set_scan(0, 0);
		run_random(8, 0, 0);
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		set_scan(63, 0);
		run_random(8, 63, 0);
		set_scan(0, 63);
		run_random(8, 0, 63);
		begin
			int lc, lr;
			lc = $urandom_range(15, 1);
			lr = $urandom_range(15, 1);
			set_scan(lc, lr);
			run_random(10, lc, lr);
		end
	endtask

	// result side holds off while items keep coming, then the sender pauses
	task automatic test_back_pressure();
		set_scan(15, 15);
		hold_cycles = HOLD_OFF_CYCLES;
		src_idle    = 1'b0;
		repeat (8) send_random_op(15, 15);
		wait_drained();
		src_idle = 1'b1;
		repeat (4) send_random_op(15, 15);
		wait_drained();
	endtask

	initial begin
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.mode       <= MODE_WRITE;
		req_ch.col        <= '0;
		req_ch.row        <= '0;
		req_ch.cell_value <= '0;
		req_ch.dir_a      <= DIR_RIGHT;
		req_ch.dir_b      <= DIR_RIGHT;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_full_grid();
		test_scan_limits();
		test_back_pressure();

		// settle, then verdict
		wait_drained();
		repeat (16) @(posedge clk);
		if (fail_cnt == 0 && answer_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: grid_wall_merge_relabel_core.f
hw/rtl/gwmr_pkg.sv
hw/rtl/gwmr_in_if.sv
hw/rtl/gwmr_out_if.sv
hw/rtl/gwmr_ram.sv
hw/rtl/gwmr_cfg.sv
hw/rtl/gwmr_ctrl.sv
hw/rtl/grid_wall_merge_relabel_core.sv
verif/tb_top.sv
